// ===== hdl/srw_pkg.sv =====
// ----------------------------------------------------------------------------
// srw_pkg
// Shared widths, codes and constants of the sequence reorder window.
// ----------------------------------------------------------------------------
`default_nettype none

package srw_pkg;

  // field widths
  localparam int unsigned SeqW     = 32;
  localparam int unsigned HandleW  = 16;
  localparam int unsigned LenW     = 11;
  localparam int unsigned TimeoutW = 24;

  // input item opcodes
  localparam logic OpArrival = 1'b0;
  localparam logic OpTick    = 1'b1;

  // most releases caused by one item
  localparam int unsigned MaxResults = 32;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);

  // idle counter saturation value and timeout reset value
  localparam logic [TimeoutW-1:0] IdleMax      = '1;
  localparam logic [TimeoutW-1:0] TimeoutReset = 24'd1000;

endpackage

`default_nettype wire

// ===== hdl/srw_ram.sv =====
// ----------------------------------------------------------------------------
// srw_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire                           clk_i,
  input  wire                           we_i,
  input  wire [$clog2(DEPTH)-1:0]       waddr_i,
  input  wire [WIDTH-1:0]               wdata_i,
  input  wire                           re_i,
  input  wire [$clog2(DEPTH)-1:0]       raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sequence_reorder_window.sv =====
// ----------------------------------------------------------------------------
// sequence_reorder_window
// Reorder window for sequence-numbered packet descriptors with idle timeout.
// ----------------------------------------------------------------------------
// Usage:
//   An item (arrival or tick) is taken when start is high and busy is low.
//   An arrival within WINDOW of the expected number is stored in its slot if
//   that slot is free; otherwise it is dropped. A tick raises the idle count
//   and, past timeout_ticks, skips the missing expected number.
//   After each item, ready slots are released in order, at most 32 per item.
//   Each release appears on the result ports for one cycle with
//   result_valid_o high; last_of_run_o marks the final one of the item.
//   The receiver cannot stall, so results are never held back.
// Sequence:
//   StIdle takes the item, StArrive or StTick stores or checks the timeout,
//   then StDrain reads the slot storage and StEmit outputs, per released
//   packet; with nothing released StDrain returns to StIdle. This walk is
//   set by the single read port of the slot storage, one slot at a time.
// Reset:
//   Expected number, idle count and all slot ready flags clear at once;
//   timeout_ticks returns to 1000. No clearing pass is needed.
// Configuration:
//   timeout_ticks is written over cfg_valid_i/cfg_ready_o, ready only when
//   idle with no item offered.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_reorder_window
  import srw_pkg::*;
#(
  parameter int unsigned WINDOW = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // command channel
  input  wire                 start,
  output logic                busy,
  input  wire                 opcode_i,
  input  wire [SeqW-1:0]      seq_in_i,
  input  wire [HandleW-1:0]   buf_handle_in_i,
  input  wire [LenW-1:0]      pkt_len_in_i,
  // configuration channel
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire [TimeoutW-1:0]  cfg_data_i,
  // result channel
  output logic                result_valid_o,
  output logic [SeqW-1:0]     seq_out_o,
  output logic [HandleW-1:0]  buf_handle_out_o,
  output logic [LenW-1:0]     pkt_len_out_o,
  output logic                last_of_run_o
);

  localparam int unsigned SlotW = $clog2(WINDOW);
  localparam int unsigned DataW = HandleW + LenW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WINDOW - 1);
  localparam logic [SlotW:0]   WindowX  = (SlotW + 1)'(WINDOW);

  typedef enum logic [2:0] {
    StIdle,
    StArrive,
    StTick,
    StDrain,
    StEmit
  } state_e;

  state_e                state_q;
  logic [SeqW-1:0]       exp_q;
  logic [SlotW-1:0]      exp_slot_q;
  logic [WINDOW-1:0]     ready_q;
  logic [TimeoutW-1:0]   idle_q;
  logic [TimeoutW-1:0]   timeout_q;
  logic [CountW-1:0]     cnt_q;
  logic [SeqW-1:0]       in_seq_q;
  logic [HandleW-1:0]    in_handle_q;
  logic [LenW-1:0]       in_len_q;
  logic [SeqW-1:0]       out_seq_q;

  logic [SeqW:0]         diff;
  logic                  in_win;
  logic [SlotW:0]        slot_sum;
  logic [SlotW-1:0]      arr_slot;
  logic                  store_ok;
  logic [TimeoutW-1:0]   idle_inc;
  logic                  skip;
  logic                  rel_ok;
  logic                  last;
  logic [SlotW-1:0]      exp_slot_next;
  logic [DataW-1:0]      rd_data;

  // slot of the number after the expected one, 2^32 wrap restarts at slot 0
  assign exp_slot_next = (exp_q == '1 || exp_slot_q == LastSlot) ? '0
                                                                 : exp_slot_q + 1'b1;

  // arrival: modular distance, borrow flags a wrap past 2^32
  assign diff     = {1'b0, in_seq_q} - {1'b0, exp_q};
  assign in_win   = diff[SeqW-1:0] < SeqW'(WINDOW);
  assign slot_sum = {1'b0, exp_slot_q} + {1'b0, diff[SlotW-1:0]};
  always_comb begin
    if (diff[SeqW]) begin
      // wrapped: the sequence number itself is below the window size
      arr_slot = in_seq_q[SlotW-1:0];
    end else if (slot_sum >= WindowX) begin
      arr_slot = SlotW'(slot_sum - WindowX);
    end else begin
      arr_slot = slot_sum[SlotW-1:0];
    end
  end
  assign store_ok = (state_q == StArrive) && in_win && !ready_q[arr_slot];

  // tick: saturating idle count and timeout check
  assign idle_inc = (idle_q == IdleMax) ? idle_q : idle_q + 1'b1;
  assign skip     = (idle_inc > timeout_q) && !ready_q[exp_slot_q];

  // release control
  assign rel_ok = ready_q[exp_slot_q] && (cnt_q < CountW'(MaxResults));
  assign last   = !rel_ok;

  // slot storage: handle and length
  srw_ram #(
    .WIDTH(DataW),
    .DEPTH(WINDOW)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (store_ok),
    .waddr_i(arr_slot),
    .wdata_i({in_len_q, in_handle_q}),
    .re_i   ((state_q == StDrain) && rel_ok),
    .raddr_i(exp_slot_q),
    .rdata_o(rd_data)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      exp_q      <= '0;
      exp_slot_q <= '0;
      ready_q    <= '0;
      idle_q     <= '0;
      timeout_q  <= TimeoutReset;
      cnt_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
      case (state_q)
        StIdle: begin
          if (start) begin
            cnt_q   <= '0;
            state_q <= (opcode_i == OpTick) ? StTick : StArrive;
          end
        end
        StArrive: begin
          if (store_ok) begin
            ready_q[arr_slot] <= 1'b1;
          end
          state_q <= StDrain;
        end
        StTick: begin
          if (skip) begin
            exp_q      <= exp_q + 1'b1;
            exp_slot_q <= exp_slot_next;
            idle_q     <= '0;
          end else begin
            idle_q <= idle_inc;
          end
          state_q <= StDrain;
        end
        StDrain: begin
          if (rel_ok) begin
            ready_q[exp_slot_q] <= 1'b0;
            exp_q      <= exp_q + 1'b1;
            exp_slot_q <= exp_slot_next;
            idle_q     <= '0;
            cnt_q      <= cnt_q + 1'b1;
            state_q    <= StEmit;
          end else begin
            state_q <= StIdle;
          end
        end
        StEmit: begin
          state_q <= last ? StIdle : StDrain;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      in_seq_q    <= seq_in_i;
      in_handle_q <= buf_handle_in_i;
      in_len_q    <= pkt_len_in_i;
    end
    if (state_q == StDrain) begin
      out_seq_q <= exp_q;
    end
  end

  // outputs
  assign busy             = (state_q != StIdle);
  assign cfg_ready_o      = (state_q == StIdle) && !start;
  assign result_valid_o   = (state_q == StEmit);
  assign seq_out_o        = out_seq_q;
  assign buf_handle_out_o = rd_data[HandleW-1:0];
  assign pkt_len_out_o    = rd_data[DataW-1:HandleW];
  assign last_of_run_o    = last;

endmodule

`default_nettype wire
